/* design/tsg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, constants and fixed-point helpers of the turtle segment
// generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int unsigned DefStackDepth = 64;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned HeadW   = 6;
  localparam int unsigned StepW   = 16;
  localparam int unsigned DispW   = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [HeadW-1:0] HeadCount = 6'd48;

  localparam logic [CfgIdxW-1:0] CfgStepLength   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAngleStep    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStartHeading = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartX       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStartY       = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDrawMask     = 3'd5;

  localparam logic [7:0] SymF     = 8'h46;
  localparam logic [7:0] SymX     = 8'h58;
  localparam logic [7:0] SymY     = 8'h59;
  localparam logic [7:0] SymZ     = 8'h5A;
  localparam logic [7:0] SymPlus  = 8'h2B;
  localparam logic [7:0] SymMinus = 8'h2D;
  localparam logic [7:0] SymPush  = 8'h5B;
  localparam logic [7:0] SymPop   = 8'h5D;

  typedef enum logic [2:0] {
    OpNop,
    OpDraw,
    OpTurnMinus,
    OpTurnPlus,
    OpPush,
    OpPop
  } op_e;

  typedef enum logic [1:0] {
    StSegment   = 2'd0,
    StOverflow  = 2'd1,
    StUnderflow = 2'd2
  } status_e;

  typedef struct packed {
    op_e  op;
    logic first;
  } cmd_t;

  typedef struct packed {
    logic        [StepW-1:0]  step_length;
    logic        [HeadW-1:0]  angle_step;
    logic        [HeadW-1:0]  start_heading;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic        [3:0]        draw_mask;
  } cfg_t;

  typedef struct packed {
    logic        [HeadW-1:0]  heading;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pose_t;

  function automatic logic [HeadW-1:0] mod48(input logic [HeadW-1:0] v);
    mod48 = (v >= HeadCount) ? v - HeadCount : v;
  endfunction

  // Cosine of k * 7.5 degrees for k = 0..12, Q1.14.
  function automatic logic [14:0] cos_quarter(input logic [3:0] k);
    case (k)
      4'd0:    cos_quarter = 15'd16384;
      4'd1:    cos_quarter = 15'd16244;
      4'd2:    cos_quarter = 15'd15826;
      4'd3:    cos_quarter = 15'd15137;
      4'd4:    cos_quarter = 15'd14189;
      4'd5:    cos_quarter = 15'd12998;
      4'd6:    cos_quarter = 15'd11585;
      4'd7:    cos_quarter = 15'd9974;
      4'd8:    cos_quarter = 15'd8192;
      4'd9:    cos_quarter = 15'd6270;
      4'd10:   cos_quarter = 15'd4240;
      4'd11:   cos_quarter = 15'd2139;
      default: cos_quarter = 15'd0;
    endcase
  endfunction

  function automatic logic [HeadW-1:0] sin_heading(input logic [HeadW-1:0] h);
    sin_heading = (h >= 6'd12) ? h - 6'd12 : h + 6'd36;
  endfunction

  // Rounded step_length * cos(h), half away from zero; step_length Q8.8, result signed Q10.8.
  function automatic logic signed [DispW-1:0] disp(input logic [HeadW-1:0] h,
                                                   input logic [StepW-1:0] step);
    logic        neg;
    logic [3:0]  idx;
    logic [14:0] mag;
    logic [30:0] prod;
    logic [30:0] rnd;
    logic [16:0] r;
    if (h < 6'd12) begin
      neg = 1'b0;
      idx = h[3:0];
    end else if (h < 6'd24) begin
      neg = 1'b1;
      idx = 4'(6'd24 - h);
    end else if (h < 6'd36) begin
      neg = 1'b1;
      idx = 4'(h - 6'd24);
    end else begin
      neg = 1'b0;
      idx = 4'(HeadCount - h);
    end
    mag  = cos_quarter(idx);
    prod = 31'(step) * 31'(mag);
    rnd  = (prod + 31'd8192) >> 14;
    r    = rnd[16:0];
    disp = neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic logic signed [CoordW-1:0] sat_add(
      input logic signed [CoordW-1:0] a, input logic signed [DispW-1:0] b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} + {{(CoordW+1-DispW){b[DispW-1]}}, b};
    if (s[CoordW] != s[CoordW-1]) begin
      sat_add = s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      sat_add = s[CoordW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* design/tsg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_sym_if / tsg_seg_if
// Valid/ready channels for the symbol requests and the segment results.
// ----------------------------------------------------------------------------
interface tsg_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       first;

  modport source (output valid, symbol, first, input ready);
  modport sink   (input valid, symbol, first, output ready);
endinterface

interface tsg_seg_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] seg_x0;
  logic signed [23:0] seg_y0;
  logic signed [23:0] seg_x1;
  logic signed [23:0] seg_y1;
  logic        [1:0]  status;

  modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, status, input ready);
  modport sink   (input valid, seg_x0, seg_y0, seg_x1, seg_y1, status, output ready);
endinterface
`default_nettype wire

/* design/tsg_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_front
// Accepts symbol requests, decodes them into turtle commands and forwards
// the ones with an effect, and any with first set, to the command queue.
// ----------------------------------------------------------------------------
module tsg_front import tsg_pkg::*; (
  tsg_sym_if.sink   sym_i,
  input  wire [3:0] draw_mask_i,
  input  wire       q_full_i,
  output logic      q_push_o,
  output cmd_t      q_cmd_o
);

  op_e op;

  always_comb begin
    unique case (sym_i.symbol)
      SymF:     op = draw_mask_i[0] ? OpDraw : OpNop;
      SymX:     op = draw_mask_i[1] ? OpDraw : OpNop;
      SymY:     op = draw_mask_i[2] ? OpDraw : OpNop;
      SymZ:     op = draw_mask_i[3] ? OpDraw : OpNop;
      SymPlus:  op = OpTurnMinus;
      SymMinus: op = OpTurnPlus;
      SymPush:  op = OpPush;
      SymPop:   op = OpPop;
      default:  op = OpNop;
    endcase
  end

  assign sym_i.ready   = ~q_full_i;
  assign q_cmd_o.op    = op;
  assign q_cmd_o.first = sym_i.first;
  assign q_push_o      = sym_i.valid & ~q_full_i & (sym_i.first | (op != OpNop));

endmodule
`default_nettype wire

/* design/tsg_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_fifo
// Four-entry command queue between the decoder and the pose engine.
// ----------------------------------------------------------------------------
module tsg_fifo import tsg_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  wire  pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  cmd_t              entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

/* design/tsg_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsg_back
// Pose engine: executes turtle commands, keeps position, heading and the
// pose stack, and registers the segment or status result.
// ----------------------------------------------------------------------------
module tsg_back import tsg_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  cfg_t      cfg_i,
  input  wire       cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  tsg_seg_if.source seg_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  logic signed [CoordW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic        [HeadW-1:0]  head_q, head_d;
  logic        [CntW-1:0]   cnt_q, cnt_d;
  logic signed [DispW-1:0]  dx_q, dy_q, sdx_q, sdy_q;
  pose_t                    tos_q, nxt_q;
  pose_t                    stack_mem [STACK_DEPTH];

  logic                     exec;
  logic signed [CoordW-1:0] bx, by, nx, ny;
  logic        [HeadW-1:0]  bh;
  logic        [6:0]        turn_sum;
  logic        [CntW-1:0]   bcnt, cnt_m1, cnt_m3;
  logic signed [DispW-1:0]  ux, uy;
  logic                     push_en, pop_en, emit;
  status_e                  status;

  logic                     out_vld_q;
  logic signed [CoordW-1:0] x0_q, y0_q, x1_q, y1_q;
  logic        [1:0]        st_q;

  assign exec      = cmd_valid_i & (~out_vld_q | seg_o.ready);
  assign cmd_pop_o = exec;

  always_comb begin
    bx       = cmd_i.first ? cfg_i.start_x : pos_x_q;
    by       = cmd_i.first ? cfg_i.start_y : pos_y_q;
    bh       = cmd_i.first ? cfg_i.start_heading : head_q;
    bcnt     = cmd_i.first ? '0 : cnt_q;
    ux       = cmd_i.first ? sdx_q : dx_q;
    uy       = cmd_i.first ? sdy_q : dy_q;
    nx       = sat_add(bx, ux);
    ny       = sat_add(by, uy);
    cnt_m1   = bcnt - CntW'(1);
    cnt_m3   = bcnt - CntW'(3);
    turn_sum = {1'b0, bh} + {1'b0, cfg_i.angle_step};

    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    push_en  = 1'b0;
    pop_en   = 1'b0;
    emit     = 1'b0;
    status   = StSegment;

    if (exec) begin
      pos_x_d = bx;
      pos_y_d = by;
      head_d  = bh;
      cnt_d   = bcnt;
      unique case (cmd_i.op)
        OpDraw: begin
          pos_x_d = nx;
          pos_y_d = ny;
          emit    = 1'b1;
        end
        OpTurnMinus: begin
          head_d = (bh >= cfg_i.angle_step) ? bh - cfg_i.angle_step
                                            : bh + HeadCount - cfg_i.angle_step;
        end
        OpTurnPlus: begin
          head_d = (turn_sum >= 7'(HeadCount)) ? 6'(turn_sum - 7'(HeadCount))
                                                : turn_sum[HeadW-1:0];
        end
        OpPush: begin
          if (bcnt >= CntW'(STACK_DEPTH)) begin
            emit   = 1'b1;
            status = StOverflow;
          end else begin
            push_en = 1'b1;
            cnt_d   = bcnt + CntW'(1);
          end
        end
        OpPop: begin
          if (bcnt == '0) begin
            emit   = 1'b1;
            status = StUnderflow;
          end else begin
            pop_en  = 1'b1;
            cnt_d   = cnt_m1;
            pos_x_d = tos_q.x;
            pos_y_d = tos_q.y;
            head_d  = tos_q.heading;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= 24'sd102400;
      pos_y_q   <= 24'sd25600;
      head_q    <= 6'd12;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      if (exec) begin
        out_vld_q <= emit;
      end else if (seg_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= disp(head_d, cfg_i.step_length);
    dy_q  <= disp(sin_heading(head_d), cfg_i.step_length);
    sdx_q <= disp(cfg_i.start_heading, cfg_i.step_length);
    sdy_q <= disp(sin_heading(cfg_i.start_heading), cfg_i.step_length);
    if (exec && emit) begin
      x0_q <= bx;
      y0_q <= by;
      x1_q <= (status == StSegment) ? nx : bx;
      y1_q <= (status == StSegment) ? ny : by;
      st_q <= status;
    end
  end

  // The top entry lives in tos_q and the one below it in nxt_q; the memory
  // holds the deeper entries and is read one pop ahead.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      if (bcnt != '0) begin
        stack_mem[cnt_m1[AddrW-1:0]] <= tos_q;
      end
      tos_q <= '{heading: bh, x: bx, y: by};
      nxt_q <= tos_q;
    end else if (pop_en) begin
      tos_q <= nxt_q;
      nxt_q <= stack_mem[cnt_m3[AddrW-1:0]];
    end
  end

  assign seg_o.valid  = out_vld_q;
  assign seg_o.seg_x0 = x0_q;
  assign seg_o.seg_y0 = y0_q;
  assign seg_o.seg_x1 = x1_q;
  assign seg_o.seg_y1 = y1_q;
  assign seg_o.status = st_q;

endmodule
`default_nettype wire

/* design/turtle_segment_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// turtle_segment_generator
// L-system turtle interpreter producing line segments from a symbol stream.
// ----------------------------------------------------------------------------
// One symbol request is accepted per clock cycle while the command queue is
// not full. A decoder places each symbol that has an effect, or has first set,
// in a four-entry command queue; the pose engine takes one command per cycle
// unless an unaccepted result is held. Position, heading and the displacement
// for the current heading are recomputed every cycle in the pose engine, which
// sets the rate of one symbol per cycle. Requests stall only when the result
// register is held by the consumer long enough for the queue to fill. The pose
// stack keeps its top two entries in registers and the rest in a
// STACK_DEPTH-entry memory. Configuration writes change the start pose only on
// a request with first set; they must be made while no request is in flight.
module turtle_segment_generator import tsg_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [CfgIdxW-1:0] cfg_idx_i,
  input  wire  [CfgDatW-1:0] cfg_wdata_i,
  tsg_sym_if.sink            sym_i,
  tsg_seg_if.source          seg_o
);

  cfg_t cfg_q;
  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_cmd_in, q_cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_length   <= 16'd768;
      cfg_q.angle_step    <= 6'd3;
      cfg_q.start_heading <= 6'd12;
      cfg_q.start_x       <= 24'sd102400;
      cfg_q.start_y       <= 24'sd25600;
      cfg_q.draw_mask     <= 4'd11;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStepLength:   cfg_q.step_length   <= cfg_wdata_i[StepW-1:0];
        CfgAngleStep:    cfg_q.angle_step    <= mod48(cfg_wdata_i[HeadW-1:0]);
        CfgStartHeading: cfg_q.start_heading <= mod48(cfg_wdata_i[HeadW-1:0]);
        CfgStartX:       cfg_q.start_x       <= $signed(cfg_wdata_i[CoordW-1:0]);
        CfgStartY:       cfg_q.start_y       <= $signed(cfg_wdata_i[CoordW-1:0]);
        CfgDrawMask:     cfg_q.draw_mask     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  tsg_front u_front (
    .sym_i       (sym_i),
    .draw_mask_i (cfg_q.draw_mask),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in)
  );

  tsg_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd_out)
  );

  tsg_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .seg_o       (seg_o)
  );

endmodule
`default_nettype wire
